@@ sv/infix_front_coding_encoder_core_macros.svh @@
// Assertion helpers shared by the checker files of this block.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef INFIX_FRONT_CODING_ENCODER_CORE_MACROS_SVH
`define INFIX_FRONT_CODING_ENCODER_CORE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define IFCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define IFCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/ifce_pkg.sv @@
package ifce_pkg;

	localparam int FIELD_BYTES = 20;
	localparam int KEY_BITS    = FIELD_BYTES * 8;
	localparam int HEAD_W      = 64;
	localparam int MID_W       = 64;
	localparam int TAIL_W      = 32;
	localparam int LEN_W       = 5;
	localparam int CODE_W      = 8;
	localparam int KEPT_W      = 4;
	localparam int KEPT_MAX    = 15;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int FILL_W      = 8;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_MARKER = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_UTF8_MODE         = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_PER_BLOCK = 2'd1;

	localparam logic [FILL_W-1:0] EPB_RESET = 8'd64;

	// A UTF-8 continuation byte has the pattern 10xxxxxx.
	localparam logic [7:0] LEAD_MASK = 8'hC0;
	localparam logic [7:0] CONT_PAT  = 8'h80;

	typedef logic [KEY_BITS-1:0]    key_t;
	typedef logic [LEN_W-1:0]       len_t;
	typedef logic [FIELD_BYTES-1:0] bytemask_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic      entry;   // an entry record is to be emitted
		logic      marker;  // a block-end marker is to be emitted (after the entry, if any)
		key_t      key;     // key bytes, zero past len
		len_t      len;
		bytemask_t vmask;   // byte positions that match and close a whole character
		len_t      chars;
		logic      head;
	} qent_t;

endpackage

@@ sv/ifce_channels.sv @@
interface ifce_in_if;
	import ifce_pkg::*;
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [HEAD_W-1:0] key_head;
	logic [MID_W-1:0]  key_mid;
	logic [TAIL_W-1:0] key_tail;
	logic [LEN_W-1:0]  key_bytes;

	modport source (output valid, cmd, key_head, key_mid, key_tail, key_bytes, input ready);
	modport sink (input valid, cmd, key_head, key_mid, key_tail, key_bytes, output ready);
endinterface

interface ifce_out_if;
	import ifce_pkg::*;
	logic              valid;
	logic              ready;
	logic              kind;
	logic [CODE_W-1:0] share_code;
	logic [HEAD_W-1:0] suffix_head;
	logic [MID_W-1:0]  suffix_mid;
	logic [TAIL_W-1:0] suffix_tail;
	logic [LEN_W-1:0]  suffix_bytes;
	logic              block_head;
	logic              last;

	modport source (output valid, kind, share_code, suffix_head, suffix_mid, suffix_tail,
		suffix_bytes, block_head, last, input ready);
	modport sink (input valid, kind, share_code, suffix_head, suffix_mid, suffix_tail,
		suffix_bytes, block_head, last, output ready);
endinterface

interface ifce_cfg_if;
	import ifce_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/infix_front_coding_encoder_core.sv @@
// Front-coding encoder for sorted infix keys of up to 20 bytes.
// The keys channel takes one word per key: cmd selects encode or finish, the key
// arrives left aligned in key_head, key_mid and key_tail, and key_bytes gives its length.
// The codes channel returns entry records (edit code plus the bytes not shared with the
// previous key) and block-end markers; last marks the final word caused by an input word.
// The cfg channel writes utf8_mode (index 0) and entries_per_block (index 1); it is
// always ready and is meant to be written only while the encoder is idle.
// The front compares each key against the previous one and classifies it in the cycle
// it is accepted, so one key enters per clock while the queue has room. A two-word
// queue separates it from the back, which builds the result and holds it in the
// output register. A result passes through a queue slot and then the output register
// before it is presented on codes. The back sends one word per cycle while the receiver
// is ready, so a key that closes a block costs two output words (record, then marker).
// When the receiver stalls, the output word holds, the queue fills, and keys.ready
// drops once both queue slots are taken; nothing is lost or repeated.
// Reset clears the previous-key flag, the block fill count and the queue, and sets
// utf8_mode to 0 and entries_per_block to 64. There is no clearing pass.
module infix_front_coding_encoder_core import ifce_pkg::*; #(
	parameter int MAX_KEY_BYTES = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	ifce_in_if.sink    keys,
	ifce_out_if.source codes,
	ifce_cfg_if.sink   cfg
);

	logic              utf8_q;
	logic [FILL_W-1:0] epb_q;

	logic  push;
	logic  full;
	logic  pop;
	logic  nonempty;
	qent_t push_data;
	qent_t head;

	// Configuration writes complete in the cycle they are offered.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_q <= 1'b0;
			epb_q  <= EPB_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_UTF8_MODE:         utf8_q <= cfg.data[0];
				REG_ENTRIES_PER_BLOCK: epb_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// The front owns the sequencing state: previous key, its flag and the block fill.
	ifce_front #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.keys             (keys),
		.utf8_mode        (utf8_q),
		.entries_per_block(epb_q),
		.full             (full),
		.push             (push),
		.push_data        (push_data)
	);

	ifce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.head     (head)
	);

	// The back turns each queued word into one or two output words.
	ifce_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.nonempty(nonempty),
		.head    (head),
		.pop     (pop),
		.codes   (codes)
	);

endmodule

@@ sv/ifce_front.sv @@
module ifce_front import ifce_pkg::*; #(
	parameter int MAX_KEY_BYTES = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	ifce_in_if.sink           keys,
	input  logic              utf8_mode,
	input  logic [FILL_W-1:0] entries_per_block,
	input  logic              full,
	output logic              push,
	output qent_t             push_data
);

	localparam int   KEY_LIMIT = (MAX_KEY_BYTES < FIELD_BYTES) ? MAX_KEY_BYTES : FIELD_BYTES;
	localparam len_t LIMIT     = LEN_W'(KEY_LIMIT);

	key_t              prev_key_q;
	len_t              prev_len_q;
	logic              have_prev_q;
	logic [FILL_W-1:0] fill_q;

	key_t              raw;
	key_t              key;
	len_t              len;
	len_t              chars;
	bytemask_t         in_len, lead, lead_nx, eqm, m, bnd;
	logic [FILL_W-1:0] fill_next;
	logic              ends_block;
	logic              acc;
	logic              is_encode;

	assign keys.ready = !full;
	assign acc        = keys.valid && keys.ready;
	assign is_encode  = (keys.cmd == CMD_ENCODE);

	always_comb begin
		raw = {keys.key_head, keys.key_mid, keys.key_tail};
		len = (keys.key_bytes > LIMIT) ? LIMIT : keys.key_bytes;
		for (int i = 0; i < FIELD_BYTES; i++) begin
			in_len[i] = LEN_W'(i) < len;
			key[KEY_BITS-1-8*i -: 8] = in_len[i] ? raw[KEY_BITS-1-8*i -: 8] : 8'h00;
			lead[i] = (key[KEY_BITS-1-8*i -: 8] & LEAD_MASK) != CONT_PAT;
			eqm[i] = in_len[i] && (LEN_W'(i) < prev_len_q)
				&& (key[KEY_BITS-1-8*i -: 8] == prev_key_q[KEY_BITS-1-8*i -: 8]);
		end
		// Bit j tells whether the byte after position j starts a character.
		lead_nx = {1'b1, lead[FIELD_BYTES-1:1]};
		for (int j = 0; j < FIELD_BYTES; j++) begin
			m[j] = have_prev_q;
			for (int k = 0; k <= j; k++) begin
				m[j] = m[j] & eqm[k];
			end
			bnd[j] = !utf8_mode || (LEN_W'(j + 1) >= len) || lead_nx[j];
		end
		chars = utf8_mode ? LEN_W'($countones(lead & in_len)) : len;
	end

	assign fill_next  = fill_q + FILL_W'(1);
	assign ends_block = (fill_next == entries_per_block);

	assign push = acc && (is_encode || (fill_q != '0));

	always_comb begin
		push_data.entry  = is_encode;
		push_data.marker = is_encode ? ends_block : 1'b1;
		push_data.key    = key;
		push_data.len    = len;
		push_data.vmask  = m & bnd;
		push_data.chars  = chars;
		push_data.head   = (fill_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			fill_q      <= '0;
		end else if (acc) begin
			if (is_encode) begin
				have_prev_q <= !ends_block;
				fill_q      <= ends_block ? '0 : fill_next;
			end else begin
				have_prev_q <= 1'b0;
				fill_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_encode) begin
			prev_key_q <= key;
			prev_len_q <= len;
		end
	end

endmodule

@@ sv/ifce_queue.sv @@
module ifce_queue import ifce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	output logic  full,
	input  logic  pop,
	output logic  nonempty,
	output qent_t head
);

	qent_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign head     = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/ifce_back.sv @@
module ifce_back import ifce_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   nonempty,
	input  qent_t  head,
	output logic   pop,
	ifce_out_if.source codes
);

	logic              ov_q;
	logic              phase_q;
	logic              kind_q;
	logic [CODE_W-1:0] code_q;
	key_t              suffix_q;
	len_t              sbytes_q;
	logic              bhead_q;
	logic              last_q;

	len_t              cnt [FIELD_BYTES];
	len_t              total;
	logic [KEPT_W-1:0] kept;
	len_t              keep_bytes;
	key_t              suffix;
	logic [CODE_W-1:0] code;
	logic              load;
	logic              emit_marker;

	always_comb begin
		keep_bytes = '0;
		for (int j = 0; j < FIELD_BYTES; j++) begin
			cnt[j] = LEN_W'($countones(head.vmask & FIELD_BYTES'((64'd1 << (j + 1)) - 64'd1)));
			if (head.vmask[j] && (cnt[j] <= LEN_W'(KEPT_MAX))) begin
				keep_bytes = LEN_W'(j + 1);
			end
		end
		total  = cnt[FIELD_BYTES-1];
		kept   = (total > LEN_W'(KEPT_MAX)) ? KEPT_W'(KEPT_MAX) : total[KEPT_W-1:0];
		suffix = head.key << {keep_bytes, 3'b000};
		code   = {kept, 4'b0000} + {3'b000, head.chars} - {4'b0000, kept};
	end

	assign load        = nonempty && (!ov_q || codes.ready);
	assign emit_marker = !head.entry || phase_q;
	assign pop         = load && (emit_marker || !head.marker);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q    <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			ov_q    <= 1'b1;
			phase_q <= !emit_marker && head.marker;
		end else if (codes.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_marker) begin
				kind_q   <= KIND_MARKER;
				code_q   <= '0;
				suffix_q <= '0;
				sbytes_q <= '0;
				bhead_q  <= 1'b0;
				last_q   <= 1'b1;
			end else begin
				kind_q   <= KIND_ENTRY;
				code_q   <= code;
				suffix_q <= suffix;
				sbytes_q <= head.len - keep_bytes;
				bhead_q  <= head.head;
				last_q   <= !head.marker;
			end
		end
	end

	assign codes.valid        = ov_q;
	assign codes.kind         = kind_q;
	assign codes.share_code   = code_q;
	assign codes.suffix_head  = suffix_q[KEY_BITS-1 -: HEAD_W];
	assign codes.suffix_mid   = suffix_q[KEY_BITS-HEAD_W-1 -: MID_W];
	assign codes.suffix_tail  = suffix_q[TAIL_W-1:0];
	assign codes.suffix_bytes = sbytes_q;
	assign codes.block_head   = bhead_q;
	assign codes.last         = last_q;

endmodule

@@ sv/ifce_checker.sv @@
`include "infix_front_coding_encoder_core_macros.svh"

module ifce_checker import ifce_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic              kind,
	input logic [CODE_W-1:0] share_code,
	input logic [HEAD_W-1:0] suffix_head,
	input logic [MID_W-1:0]  suffix_mid,
	input logic [TAIL_W-1:0] suffix_tail,
	input logic [LEN_W-1:0]  suffix_bytes,
	input logic              block_head,
	input logic              last
);

	logic [KEY_BITS+CODE_W+LEN_W+2:0] payload;
	logic                             marker_clean;

	assign payload = {kind, share_code, suffix_head, suffix_mid, suffix_tail, suffix_bytes,
		block_head, last};
	assign marker_clean = (share_code == '0) && (suffix_bytes == '0) && !block_head && last
		&& (suffix_head == '0) && (suffix_mid == '0) && (suffix_tail == '0);

	`IFCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload), "output word changed while stalled")
	`IFCE_ASSERT_NOW(a_marker_clean, out_valid && (kind == KIND_MARKER), marker_clean, "block-end marker carries data")
	`IFCE_ASSERT_NOW(a_suffix_len, out_valid, suffix_bytes <= LEN_W'(FIELD_BYTES), "suffix length out of range")
	`IFCE_ASSERT_NEXT(a_marker_follows, out_valid && out_ready && (kind == KIND_ENTRY) && !last, out_valid && (kind == KIND_MARKER), "block-end marker did not follow its record")

endmodule

bind infix_front_coding_encoder_core ifce_checker u_ifce_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (codes.valid),
	.out_ready   (codes.ready),
	.kind        (codes.kind),
	.share_code  (codes.share_code),
	.suffix_head (codes.suffix_head),
	.suffix_mid  (codes.suffix_mid),
	.suffix_tail (codes.suffix_tail),
	.suffix_bytes(codes.suffix_bytes),
	.block_head  (codes.block_head),
	.last        (codes.last)
);
